// ===== hdl/ppd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, event codes and constants for the peer delay calculator.
// No dependencies; every other file refers to this package by scoped names.
package ppd_pkg;

   // Event codes carried in the mode field
   localparam logic [1:0] MODE_REQUEST   = 2'd0;
   localparam logic [1:0] MODE_RESPONSE  = 2'd1;
   localparam logic [1:0] MODE_FOLLOW_UP = 2'd2;

   localparam int TS_WIDTH   = 64;
   localparam int SEQ_WIDTH  = 16;
   // Correction fields are nanoseconds scaled by 2^16
   localparam int CORR_SHIFT = 16;

   // One input transaction
   typedef struct packed {
      logic [1:0]         mode;
      logic               send_ok;
      logic [15:0]        seq_num;
      logic [62:0]        message_timestamp;
      logic [62:0]        receive_timestamp;
      logic signed [63:0] correction_field;
      logic [15:0]        source_port_number;
      logic [63:0]        source_clock_identity;
   } req_type;

   // One result transaction
   typedef struct packed {
      logic signed [63:0] mean_path_delay;
      logic [15:0]        matched_sequence_id;
      logic [63:0]        request_origin_ts;
      logic [63:0]        request_receipt_ts;
      logic [63:0]        response_origin_ts;
      logic [63:0]        response_receipt_ts;
      logic [63:0]        corrected_origin_ts;
      logic [15:0]        responder_port_number;
      logic [63:0]        responder_clock_identity;
      logic [63:0]        requester_clock_identity;
   } rsp_type;

   // Stored exchange state, including two running partial sums
   typedef struct packed {
      logic [SEQ_WIDTH-1:0] request_sequence;
      logic [TS_WIDTH-1:0]  send_time;
      logic [TS_WIDTH-1:0]  request_identity;
      logic [SEQ_WIDTH-1:0] response_sequence;
      logic [TS_WIDTH-1:0]  remote_receipt_time;
      logic [TS_WIDTH-1:0]  local_receive_time;
      logic [TS_WIDTH-1:0]  correction_ns;
      logic [SEQ_WIDTH-1:0] response_port;
      logic [TS_WIDTH-1:0]  response_identity;
      logic [TS_WIDTH-1:0]  remote_minus_send;    // t2 - t1
      logic [TS_WIDTH-1:0]  receive_minus_corr;   // t4 - c1
   } exch_state_type;

   // Per-cycle step control between the stages
   typedef struct packed {
      logic fire;   // the held transaction is processed at this edge
      logic emit;   // and it produces a result
   } step_ctrl_type;

   // Scaled nanoseconds to nanoseconds, arithmetic shift (floor)
   function automatic logic [TS_WIDTH-1:0] corr_to_ns(input logic [TS_WIDTH-1:0] c);
      corr_to_ns = {{CORR_SHIFT{c[TS_WIDTH-1]}}, c[TS_WIDTH-1:CORR_SHIFT]};
   endfunction

endpackage

// ===== hdl/ptp_peer_delay_calc.sv =====
`timescale 1ns / 1ps
// Peer delay calculator top level: IEEE 802.1AS style Pdelay exchange.
// Depends on ppd_pkg, ppd_in_reg, ppd_exch_state, ppd_delay_calc, ppd_out_reg.
//
//   Channel  Ports                          Direction  Payload
//   req      req_valid/req_stall/req_data   in         ppd_pkg::req_type
//   rsp      rsp_valid/rsp_stall/rsp_data   out        ppd_pkg::rsp_type
//   csr      csr_valid/csr_ready/csr_data   in         local_clock_identity
//
// One transaction per cycle sustained while the result side does not stall; a
// follow-up's arithmetic runs while the transaction sits in the input register,
// and the result lands in the result register when that transaction moves on.
// Synchronous active-high reset clears all exchange state and the identity.
// A stalled result holds the input register, which then stalls req.
// csr is always ready.
module ptp_peer_delay_calc (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ppd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ppd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [63:0]      csr_data
);

   logic [63:0]             local_id_ff;
   logic                    item_valid;
   logic                    out_ready;
   logic                    seq_match;
   ppd_pkg::req_type        item;
   ppd_pkg::exch_state_type exch;
   ppd_pkg::rsp_type        result;
   ppd_pkg::step_ctrl_type  step;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_id_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         local_id_ff <= csr_data;
      end
   end

   // Step control for the held transaction
   assign step.fire = item_valid & out_ready;
   assign step.emit = item_valid & out_ready & seq_match;

   ppd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .out_ready  (out_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   ppd_exch_state u_exch_state (
      .clock                (clock),
      .reset                (reset),
      .step                 (step),
      .item                 (item),
      .local_clock_identity (local_id_ff),
      .exch                 (exch)
   );

   ppd_delay_calc u_delay_calc (
      .item      (item),
      .exch      (exch),
      .seq_match (seq_match),
      .result    (result)
   );

   ppd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .result    (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/ppd_in_reg.sv =====
`timescale 1ns / 1ps
// Input register of the peer delay calculator: holds one transaction.
// Depends on ppd_pkg.
module ppd_in_reg (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ppd_pkg::req_type req_data,
   input  logic            out_ready,
   output logic            item_valid,
   output ppd_pkg::req_type item
);

   logic             item_valid_ff;
   logic             item_valid_in;
   ppd_pkg::req_type item_ff;

   // Hold the input while the held transaction cannot move on
   assign req_stall     = item_valid_ff & ~out_ready;
   assign item_valid_in = req_stall ? item_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

// ===== hdl/ppd_exch_state.sv =====
`timescale 1ns / 1ps
// Exchange state of the peer delay calculator: sequence counter, request
// and response captures, and running partial sums. Depends on ppd_pkg.
module ppd_exch_state (
   input  logic                    clock,
   input  logic                    reset,
   input  ppd_pkg::step_ctrl_type  step,
   input  ppd_pkg::req_type        item,
   input  logic [63:0]             local_clock_identity,
   output ppd_pkg::exch_state_type exch
);

   ppd_pkg::exch_state_type        exch_ff;
   ppd_pkg::exch_state_type        exch_in;
   logic [ppd_pkg::SEQ_WIDTH-1:0]  next_sequence_ff;
   logic [ppd_pkg::SEQ_WIDTH-1:0]  next_sequence_in;
   logic [ppd_pkg::TS_WIDTH-1:0]   new_send_time;
   logic [ppd_pkg::TS_WIDTH-1:0]   new_receipt;
   logic [ppd_pkg::TS_WIDTH-1:0]   new_receive;
   logic [ppd_pkg::TS_WIDTH-1:0]   new_corr_ns;

   // Timestamps arrive as 63 bits; a failed send records zero
   assign new_send_time = item.send_ok ? {1'b0, item.message_timestamp}
                                       : '0;
   assign new_receipt   = {1'b0, item.message_timestamp};
   assign new_receive   = {1'b0, item.receive_timestamp};
   assign new_corr_ns   = ppd_pkg::corr_to_ns(item.correction_field);

   // Update on request or response; follow-ups leave state alone
   always_comb begin
      exch_in          = exch_ff;
      next_sequence_in = next_sequence_ff;
      if (step.fire) begin
         unique case (item.mode)
            ppd_pkg::MODE_REQUEST: begin
               exch_in.request_sequence  = next_sequence_ff;
               exch_in.request_identity  = local_clock_identity;
               exch_in.send_time         = new_send_time;
               exch_in.remote_minus_send = exch_ff.remote_receipt_time - new_send_time;
               next_sequence_in          = next_sequence_ff + 16'd1;
            end
            ppd_pkg::MODE_RESPONSE: begin
               exch_in.response_sequence   = item.seq_num;
               exch_in.remote_receipt_time = new_receipt;
               exch_in.local_receive_time  = new_receive;
               exch_in.correction_ns       = new_corr_ns;
               exch_in.response_port       = item.source_port_number;
               exch_in.response_identity   = item.source_clock_identity;
               exch_in.remote_minus_send   = new_receipt - exch_ff.send_time;
               exch_in.receive_minus_corr  = new_receive - new_corr_ns;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exch_ff          <= '0;
         next_sequence_ff <= '0;
      end else begin
         exch_ff          <= exch_in;
         next_sequence_ff <= next_sequence_in;
      end
   end

   assign exch = exch_ff;

endmodule

// ===== hdl/ppd_delay_calc.sv =====
`timescale 1ns / 1ps
// Follow-up arithmetic of the peer delay calculator: sequence match,
// corrected t3 and halved mean path delay. Depends on ppd_pkg.
module ppd_delay_calc (
   input  ppd_pkg::req_type        item,
   input  ppd_pkg::exch_state_type exch,
   output logic                    seq_match,
   output ppd_pkg::rsp_type        result
);

   logic [ppd_pkg::TS_WIDTH-1:0] t3;
   logic [ppd_pkg::TS_WIDTH-1:0] c2_ns;
   logic [ppd_pkg::TS_WIDTH-1:0] t3c;
   logic [ppd_pkg::TS_WIDTH-1:0] delay_sum;
   logic [ppd_pkg::TS_WIDTH-1:0] delay_round;

   // Emit only on a follow-up that matches both stored sequence numbers
   assign seq_match = (item.mode == ppd_pkg::MODE_FOLLOW_UP)
                    && (exch.request_sequence == exch.response_sequence)
                    && (exch.response_sequence == item.seq_num);

   assign t3    = {1'b0, item.message_timestamp};
   assign c2_ns = ppd_pkg::corr_to_ns(item.correction_field);
   assign t3c   = t3 + exch.correction_ns + c2_ns;

   // (t2 - t1) + (t4 - c1) - t3 - c2, all wrapping
   assign delay_sum   = exch.remote_minus_send + exch.receive_minus_corr - t3 - c2_ns;
   // Halve toward zero: bias negative values by one, then shift
   assign delay_round = delay_sum + {{(ppd_pkg::TS_WIDTH-1){1'b0}},
                                     delay_sum[ppd_pkg::TS_WIDTH-1]};

   always_comb begin
      result.mean_path_delay          = {delay_round[ppd_pkg::TS_WIDTH-1],
                                         delay_round[ppd_pkg::TS_WIDTH-1:1]};
      result.matched_sequence_id      = exch.response_sequence;
      result.request_origin_ts        = exch.send_time;
      result.request_receipt_ts       = exch.remote_receipt_time;
      result.response_origin_ts       = t3;
      result.response_receipt_ts      = exch.local_receive_time;
      result.corrected_origin_ts      = t3c;
      result.responder_port_number    = exch.response_port;
      result.responder_clock_identity = exch.response_identity;
      result.requester_clock_identity = exch.request_identity;
   end

endmodule

// ===== hdl/ppd_out_reg.sv =====
`timescale 1ns / 1ps
// Result register of the peer delay calculator: holds one result until taken.
// Depends on ppd_pkg.
module ppd_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  ppd_pkg::step_ctrl_type step,
   input  ppd_pkg::rsp_type       result,
   output logic                   out_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ppd_pkg::rsp_type       rsp_data
);

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   ppd_pkg::rsp_type rsp_data_ff;

   // Free when empty or when the held result leaves this cycle
   assign out_ready = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      if (step.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load a new result transaction
   always_ff @(posedge clock) begin
      if (step.emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/ppd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the peer delay calculator, bound to the top level.
// Depends on ppd_pkg and ptp_peer_delay_calc.
module ppd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ppd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ppd_pkg::rsp_type rsp_data
);

   logic [63:0] chk_sum;
   logic [63:0] chk_twice;
   logic [63:0] chk_adj;

   // Rebuild the unhalved sum from the reported timestamps
   assign chk_sum   = (rsp_data.request_receipt_ts - rsp_data.request_origin_ts)
                    + (rsp_data.response_receipt_ts - rsp_data.corrected_origin_ts);
   assign chk_twice = {rsp_data.mean_path_delay[62:0], 1'b0};
   assign chk_adj   = !chk_sum[0] ? 64'd0 : (chk_sum[63] ? '1 : 64'd1);

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Stall input only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // A request-sent transaction produces no result
   a_request_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.mode == ppd_pkg::MODE_REQUEST)
      ##1 !rsp_stall |=> !rsp_valid)
      else $error("result produced for a request event");

   // Delay is the truncated half of (t2 - t1) + (t4 - t3c)
   a_delay_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> chk_sum == chk_twice + chk_adj)
      else $error("path delay inconsistent with reported timestamps");

endmodule

bind ptp_peer_delay_calc ppd_checker u_ppd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb_ptp_peer_delay_calc.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ptp_peer_delay_calc: directed table plus random exchanges;
// results checked against an in-bench Pdelay model or typed table rows. Depends on ppd_pkg.
module tb_ptp_peer_delay_calc;

   localparam logic [1:0]  MODE_UNUSED = 2'd3;
   localparam logic [62:0] TS_MAX      = '1;
   localparam logic [63:0] CORR_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] CORR_MIN    = 64'h8000_0000_0000_0000;
   localparam int          IDLE_LIMIT  = 2000;
   localparam int          LONG_HOLD   = 300;
   localparam int          PHASE_ITEMS = 370;
   localparam int          BURST_ITEMS = 64;

   typedef enum logic [1:0] {
      ROW_CHECKED,   // expected result comes from the predictor
      ROW_TYPED,     // expected result is written into the table
      ROW_SILENT     // no result may come
   } row_kind_type;

   typedef struct {
      row_kind_type     kind;
      ppd_pkg::req_type stim;
      ppd_pkg::rsp_type want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ppd_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ppd_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [63:0]      csr_data = '0;

   // Predictor state
   logic [15:0] seq_counter;
   logic [15:0] held_req_seq;
   logic [63:0] held_t1;
   logic [63:0] held_req_ident;
   logic [15:0] held_rsp_seq;
   logic [63:0] held_t2;
   logic [63:0] held_t4;
   logic [63:0] held_corr;
   logic [15:0] held_port;
   logic [63:0] held_rsp_ident;
   logic [63:0] cfg_local_ident;

   ppd_pkg::rsp_type pending_results[$];
   stim_row_type     directed_rows[$];

   int  n_items;
   int  n_results = 0;
   int  n_cfg;
   int  n_fail = 0;
   int  idle_run = 0;
   int  stall_odds;
   bit  quiet;
   bit  sender_steady;
   bit  long_hold;
   bit  hold_taken = 1'b0;

   ptp_peer_delay_calc DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Scaled nanoseconds to nanoseconds, rounding toward minus infinity
   function automatic logic [63:0] scaled_to_ns(input logic [63:0] c);
      return $signed(c) >>> 16;
   endfunction

   // Apply one event to the exchange state; return 1 when it yields a delay result
   function automatic bit advance_exchange(input ppd_pkg::req_type r,
                                           output ppd_pkg::rsp_type o);
      logic [63:0]        t3;
      logic [63:0]        t3c;
      logic signed [63:0] sum;
      o = '0;
      case (r.mode)
         ppd_pkg::MODE_REQUEST: begin
            held_req_seq   = seq_counter;
            held_req_ident = cfg_local_ident;
            seq_counter    = seq_counter + 16'd1;
            held_t1        = r.send_ok ? {1'b0, r.message_timestamp} : 64'd0;
         end
         ppd_pkg::MODE_RESPONSE: begin
            held_rsp_seq   = r.seq_num;
            held_t2        = {1'b0, r.message_timestamp};
            held_t4        = {1'b0, r.receive_timestamp};
            held_corr      = r.correction_field;
            held_port      = r.source_port_number;
            held_rsp_ident = r.source_clock_identity;
         end
         ppd_pkg::MODE_FOLLOW_UP: begin
            if (held_req_seq == held_rsp_seq && held_rsp_seq == r.seq_num) begin
               t3  = {1'b0, r.message_timestamp};
               t3c = t3 + scaled_to_ns(held_corr) + scaled_to_ns(r.correction_field);
               sum = (held_t2 - held_t1) + (held_t4 - t3c);
               o.mean_path_delay          = sum / 64'sd2;
               o.matched_sequence_id      = held_rsp_seq;
               o.request_origin_ts        = held_t1;
               o.request_receipt_ts       = held_t2;
               o.response_origin_ts       = t3;
               o.response_receipt_ts      = held_t4;
               o.corrected_origin_ts      = t3c;
               o.responder_port_number    = held_port;
               o.responder_clock_identity = held_rsp_ident;
               o.requester_clock_identity = held_req_ident;
               return 1'b1;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic ppd_pkg::req_type make_req(input logic [1:0] mode, input logic ok,
                                        input logic [15:0] seq, input logic [62:0] mts,
                                        input logic [62:0] rts, input logic [63:0] corr,
                                        input logic [15:0] port, input logic [63:0] ident);
      ppd_pkg::req_type r;
      r.mode                  = mode;
      r.send_ok               = ok;
      r.seq_num               = seq;
      r.message_timestamp     = mts;
      r.receive_timestamp     = rts;
      r.correction_field      = corr;
      r.source_port_number    = port;
      r.source_clock_identity = ident;
      return r;
   endfunction

   function automatic ppd_pkg::rsp_type make_rsp(input logic [63:0] delay,
                                        input logic [15:0] seq,
                                        input logic [63:0] t1, input logic [63:0] t2,
                                        input logic [63:0] t3, input logic [63:0] t4,
                                        input logic [63:0] t3c, input logic [15:0] port,
                                        input logic [63:0] rsp_ident,
                                        input logic [63:0] req_ident);
      ppd_pkg::rsp_type o;
      o.mean_path_delay          = delay;
      o.matched_sequence_id      = seq;
      o.request_origin_ts        = t1;
      o.request_receipt_ts       = t2;
      o.response_origin_ts       = t3;
      o.response_receipt_ts      = t4;
      o.corrected_origin_ts      = t3c;
      o.responder_port_number    = port;
      o.responder_clock_identity = rsp_ident;
      o.requester_clock_identity = req_ident;
      return o;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Small realistic times, extremes and full-range values, picked at random
   function automatic logic [62:0] rand_ts();
      logic [63:0] w;
      w = rand64();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return TS_MAX;
         2, 3, 4: return 63'($urandom_range(0, 1000000));
         default: return w[62:0];
      endcase
   endfunction

   function automatic logic [63:0] rand_corr();
      logic [63:0] mag;
      mag = 64'($urandom_range(0, 3000000));
      case ($urandom_range(0, 9))
         0:          return '0;
         1:          return CORR_MAX;
         2:          return CORR_MIN;
         3:          return '1;
         4, 5, 6:    return $urandom_range(0, 1) ? mag : -mag;
         default:    return rand64();
      endcase
   endfunction

   function automatic void add_row(input row_kind_type kind, input ppd_pkg::req_type r,
                                   input ppd_pkg::rsp_type want = '0);
      stim_row_type row;
      row.kind = kind;
      row.stim = r;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void compare_result(input ppd_pkg::rsp_type want,
                                          input ppd_pkg::rsp_type got);
      if (got.mean_path_delay !== want.mean_path_delay) begin
         $error("mean_path_delay: expected %0d, got %0d",
                want.mean_path_delay, got.mean_path_delay);
         n_fail++;
      end
      if (got.matched_sequence_id !== want.matched_sequence_id) begin
         $error("matched_sequence_id: expected %0d, got %0d",
                want.matched_sequence_id, got.matched_sequence_id);
         n_fail++;
      end
      if (got.request_origin_ts !== want.request_origin_ts) begin
         $error("request_origin_ts: expected %0h, got %0h",
                want.request_origin_ts, got.request_origin_ts);
         n_fail++;
      end
      if (got.request_receipt_ts !== want.request_receipt_ts) begin
         $error("request_receipt_ts: expected %0h, got %0h",
                want.request_receipt_ts, got.request_receipt_ts);
         n_fail++;
      end
      if (got.response_origin_ts !== want.response_origin_ts) begin
         $error("response_origin_ts: expected %0h, got %0h",
                want.response_origin_ts, got.response_origin_ts);
         n_fail++;
      end
      if (got.response_receipt_ts !== want.response_receipt_ts) begin
         $error("response_receipt_ts: expected %0h, got %0h",
                want.response_receipt_ts, got.response_receipt_ts);
         n_fail++;
      end
      if (got.corrected_origin_ts !== want.corrected_origin_ts) begin
         $error("corrected_origin_ts: expected %0h, got %0h",
                want.corrected_origin_ts, got.corrected_origin_ts);
         n_fail++;
      end
      if (got.responder_port_number !== want.responder_port_number) begin
         $error("responder_port_number: expected %0h, got %0h",
                want.responder_port_number, got.responder_port_number);
         n_fail++;
      end
      if (got.responder_clock_identity !== want.responder_clock_identity) begin
         $error("responder_clock_identity: expected %0h, got %0h",
                want.responder_clock_identity, got.responder_clock_identity);
         n_fail++;
      end
      if (got.requester_clock_identity !== want.requester_clock_identity) begin
         $error("requester_clock_identity: expected %0h, got %0h",
                want.requester_clock_identity, got.requester_clock_identity);
         n_fail++;
      end
   endfunction

   // Offer one transaction, hold it until accepted, then record what it should yield
   task automatic send_req(input ppd_pkg::req_type r, input row_kind_type kind = ROW_CHECKED,
                           input ppd_pkg::rsp_type want = '0);
      ppd_pkg::rsp_type pred;
      bit               hit;
      int               gap;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
      hit = advance_exchange(r, pred);
      n_items++;
      case (kind)
         ROW_CHECKED: if (hit) pending_results.push_back(pred);
         ROW_TYPED:   pending_results.push_back(want);
         default:     ;
      endcase
      if (!sender_steady && !quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait out every pending result plus the pipeline depth
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_identity(input logic [63:0] value);
      drain_block();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_local_ident = value;
      n_cfg++;
   endtask

   // Request, response with the captured sequence, then one to three follow-ups;
   // now and then the sequence numbers are broken
   task automatic run_exchange();
      logic [15:0] seq;
      int          n_fu;
      send_req(make_req(ppd_pkg::MODE_REQUEST, ($urandom_range(0, 7) != 0),
                        16'($urandom_range(0, 65535)), rand_ts(), rand_ts(), rand_corr(),
                        16'($urandom_range(0, 65535)), rand64()));
      seq = held_req_seq;
      if ($urandom_range(0, 9) == 0) seq = seq + 16'($urandom_range(1, 3));
      send_req(make_req(ppd_pkg::MODE_RESPONSE, 1'($urandom_range(0, 1)), seq, rand_ts(),
                        rand_ts(), rand_corr(), 16'($urandom_range(0, 65535)), rand64()));
      n_fu = $urandom_range(1, 3);
      repeat (n_fu) begin
         seq = held_rsp_seq;
         if ($urandom_range(0, 9) == 0) seq = 16'($urandom_range(0, 65535));
         send_req(make_req(ppd_pkg::MODE_FOLLOW_UP, 1'($urandom_range(0, 1)), seq,
                           rand_ts(), rand_ts(), rand_corr(),
                           16'($urandom_range(0, 65535)), rand64()));
      end
   endtask

   task automatic run_random(input int count);
      int start;
      start = n_items;
      while (n_items - start < count) begin
         if ($urandom_range(0, 3) != 0)
            run_exchange();
         else
            send_req(make_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              16'($urandom_range(0, 65535)), rand_ts(), rand_ts(),
                              rand_corr(), 16'($urandom_range(0, 65535)), rand64()));
      end
   endtask

   // Stall the result side for a long stretch while follow-ups keep arriving
   task automatic fill_under_hold();
      send_req(make_req(ppd_pkg::MODE_REQUEST, 1'b1, '0, rand_ts(), '0, '0, '0, '0));
      send_req(make_req(ppd_pkg::MODE_RESPONSE, 1'b0, held_req_seq, rand_ts(), rand_ts(),
                        rand_corr(), 16'($urandom_range(0, 65535)), rand64()));
      sender_steady = 1'b1;
      long_hold     = 1'b1;
      repeat (24)
         send_req(make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b0, held_rsp_seq, rand_ts(), '0,
                           rand_corr(), '0, '0));
      sender_steady = 1'b0;
      drain_block();
   endtask

   // Result side: random stall bursts, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && stall_odds > 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check every accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction, sequence %0d", rsp_data.matched_sequence_id);
            n_fail++;
         end else begin
            compare_result(pending_results.pop_front(), rsp_data);
            n_results++;
         end
      end
   end

   // Abort when no transaction moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_run <= 0;
      end else if (idle_run >= IDLE_LIMIT) begin
         $error("watchdog: no transaction for %0d cycles, %0d results pending",
                idle_run, pending_results.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   initial begin
      logic [63:0] idents[5];
      seq_counter     = '0;
      held_req_seq    = '0;
      held_t1         = '0;
      held_req_ident  = '0;
      held_rsp_seq    = '0;
      held_t2         = '0;
      held_t4         = '0;
      held_corr       = '0;
      held_port       = '0;
      held_rsp_ident  = '0;
      cfg_local_ident = '0;
      n_items         = 0;
      n_cfg           = 0;
      stall_odds      = 6;
      quiet           = 1'b0;
      sender_steady   = 1'b0;
      long_hold       = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Follow-up with sequence zero matches the cleared state
      add_row(ROW_TYPED, make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b0, '0, '0, '0, '0, '0, '0),
              make_rsp('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
      // Unused mode with every payload bit set: ignored
      add_row(ROW_SILENT, make_req(MODE_UNUSED, 1'b1, '1, TS_MAX, TS_MAX, '1, '1, '1));
      add_row(ROW_SILENT, make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b1, 16'd1, '0, '0, '0, '0, '0));
      // Plain exchange with sequence 0
      add_row(ROW_SILENT, make_req(ppd_pkg::MODE_REQUEST, 1'b1, '0, 63'd100, '0, '0, '0, '0));
      add_row(ROW_SILENT, make_req(ppd_pkg::MODE_RESPONSE, 1'b0, '0, 63'd200, 63'd400, '0,
                                   '1, '1));
      add_row(ROW_TYPED, make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b0, '0, 63'd300, '0, '0, '0, '0),
              make_rsp(64'd100, '0, 64'd100, 64'd200, 64'd300, 64'd400, 64'd300, '1, '1, '0));
      // Failed send still consumes sequence 1; extreme times and corrections
      add_row(ROW_SILENT, make_req(ppd_pkg::MODE_REQUEST, 1'b0, '0, TS_MAX, '0, '0, '0, '0));
      add_row(ROW_SILENT, make_req(ppd_pkg::MODE_RESPONSE, 1'b0, 16'd1, TS_MAX, '0, '1,
                                   '0, '0));
      add_row(ROW_CHECKED, make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b0, 16'd1, '0, '0, CORR_MAX,
                                    '0, '0));
      add_row(ROW_CHECKED, make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b1, 16'd1, TS_MAX, TS_MAX,
                                    CORR_MIN, '1, '1));
      add_row(ROW_SILENT, make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b0, '0, '0, '0, '0, '0, '0));
      // Response ahead of its request: request side does not match
      add_row(ROW_SILENT, make_req(ppd_pkg::MODE_RESPONSE, 1'b1, 16'd2, '0, TS_MAX, CORR_MIN,
                                   '1, '1));
      add_row(ROW_SILENT, make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b0, 16'd2, '0, '0, '0, '0, '0));
      add_row(ROW_SILENT, make_req(ppd_pkg::MODE_REQUEST, 1'b1, '1, '0, TS_MAX, '1, '1, '1));
      add_row(ROW_CHECKED, make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b0, 16'd2, TS_MAX, '0,
                                    CORR_MAX, '0, '0));
      // Small odd sums: halving truncates toward zero, corrections floor
      add_row(ROW_SILENT, make_req(ppd_pkg::MODE_REQUEST, 1'b1, '0, 63'd10, '0, '0, '0, '0));
      add_row(ROW_SILENT, make_req(ppd_pkg::MODE_RESPONSE, 1'b0, 16'd3, 63'd10, 63'd20, '0,
                                   16'd5, 64'd6));
      add_row(ROW_TYPED, make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b0, 16'd3, 63'd21, '0, '0,
                                  '0, '0),
              make_rsp('0, 16'd3, 64'd10, 64'd10, 64'd21, 64'd20, 64'd21, 16'd5, 64'd6, '0));
      add_row(ROW_TYPED, make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b0, 16'd3, 63'd20, '0, '1,
                                  '0, '0),
              make_rsp('0, 16'd3, 64'd10, 64'd10, 64'd20, 64'd20, 64'd19, 16'd5, 64'd6, '0));
      add_row(ROW_TYPED, make_req(ppd_pkg::MODE_FOLLOW_UP, 1'b0, 16'd3, 63'd23, '0, '0,
                                  '0, '0),
              make_rsp('1, 16'd3, 64'd10, 64'd10, 64'd23, 64'd20, 64'd23, 16'd5, 64'd6, '0));

      foreach (directed_rows[i])
         send_req(directed_rows[i].stim, directed_rows[i].kind, directed_rows[i].want);

      idents[0] = '1;
      idents[1] = rand64();
      idents[2] = CORR_MIN;
      idents[3] = '0;
      idents[4] = rand64();

      for (int p = 0; p < 5; p++) begin
         write_identity(idents[p]);
         case (p)
            0: stall_odds = 3;
            1: stall_odds = 30;
            2: stall_odds = 8;
            default: stall_odds = 0;
         endcase
         if (p == 1) fill_under_hold();
         // Burst of requests back to back
         if (p == 2) begin
            sender_steady = 1'b1;
            repeat (BURST_ITEMS)
               send_req(make_req(ppd_pkg::MODE_REQUEST, 1'($urandom_range(0, 1)),
                                 16'($urandom_range(0, 65535)), rand_ts(), rand_ts(),
                                 rand_corr(), '0, '0));
            sender_steady = 1'b0;
         end
         if (p == 4) quiet = 1'b1;
         run_random(PHASE_ITEMS);
      end

      drain_block();
      repeat (4) @(posedge clock);
      $display("Covered %0d input transactions, %0d delay results, %0d identity writes,",
               n_items, n_results, n_cfg);
      $display("a back-to-back request burst, long result hold and both idle patterns; %0d %s",
               n_fail, "mismatches");
      if (n_fail == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== ptp_peer_delay_calc.f =====
hdl/ppd_pkg.sv
hdl/ppd_in_reg.sv
hdl/ppd_exch_state.sv
hdl/ppd_delay_calc.sv
hdl/ppd_out_reg.sv
hdl/ptp_peer_delay_calc.sv
hdl/ppd_checker.sv
tb/sv/tb_ptp_peer_delay_calc.sv
